>>> hdl/tdc_hit_histogrammer_defines.svh
// ----------------------------------------------------------------------------
// TDC hit histogrammer assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TDC_HIT_HISTOGRAMMER_DEFINES_SVH
`define TDC_HIT_HISTOGRAMMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDCH_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tdc_hit_histogrammer: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TDCH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tdc_hit_histogrammer: assertion failed");

`endif

>>> hdl/tdch_pkg.sv
// ----------------------------------------------------------------------------
// TDC hit histogrammer package
// Geometry, counter widths, op codes and shared helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tdch_pkg;

  localparam int ROWS        = 8;
  localparam int COLS        = 4;
  localparam int MULT_BINS   = 64;
  localparam int COUNT_WIDTH = 32;

  localparam int NCHAN = ROWS * COLS;
  localparam int CH_W  = (NCHAN > 1) ? $clog2(NCHAN) : 1;
  localparam int BIN_W = $clog2(MULT_BINS);
  localparam int OUT_W = 32;
  localparam int EV_W  = 16;

  localparam int APB_AW = 3;
  localparam int REG_TIME_THRESHOLD = 0;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [EV_W-1:0]        evcnt_t;

  localparam cnt_t   CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam evcnt_t EV_MAX  = {EV_W{1'b1}};

  typedef enum logic [1:0] {
    OP_HIT  = 2'd0,
    OP_END  = 2'd1,
    OP_RDCH = 2'd2,
    OP_RDMB = 2'd3
  } op_e;

  // Item as it leaves the front stage and waits for its RAM read data.
  typedef struct packed {
    op_e              op;
    logic             hit_ok;
    logic             rd_ok;
    logic [CH_W-1:0]  ch_addr;
    logic [BIN_W-1:0] bin_addr;
    logic [OUT_W-1:0] evt_value;
    logic [OUT_W-1:0] total;
    logic [OUT_W-1:0] hit_events;
    logic [OUT_W-1:0] events;
  } s1_t;

  function automatic cnt_t sat_inc(cnt_t c);
    return (c == CNT_MAX) ? c : c + cnt_t'(1);
  endfunction

  function automatic logic [OUT_W-1:0] to_out(cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/tdch_apb_regs.sv
// ----------------------------------------------------------------------------
// TDC hit histogrammer configuration registers
// APB-style slave holding the hit time threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module tdch_apb_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tdch_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic signed [31:0]              threshold_o
);
  import tdch_pkg::*;

  logic [31:0] thresh_q, thresh_d;
  logic        sel_thresh;

  assign sel_thresh = (int'(paddr[APB_AW-1:2]) == REG_TIME_THRESHOLD);
  assign pready     = 1'b1;

  always_comb begin
    thresh_d = thresh_q;
    if (psel && penable && pwrite && sel_thresh) begin
      thresh_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  assign prdata      = sel_thresh ? thresh_q : '0;
  assign threshold_o = $signed(thresh_q);

endmodule

`default_nettype wire

>>> hdl/tdch_ram.sv
// ----------------------------------------------------------------------------
// TDC hit histogrammer bin RAM
// One write and one registered read port, write-first on a same-address
// collision, with per-entry valid bits so unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tdch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rd_q;
  logic             rvalid_q;
  logic             collide;

  assign collide = we_i && (waddr_i == raddr_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= collide ? wdata_i : mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i] || collide;
      end
    end
  end

  assign rdata_o = rvalid_q ? rd_q : '0;

endmodule

`default_nettype wire

>>> hdl/tdch_front.sv
// ----------------------------------------------------------------------------
// TDC hit histogrammer front stage
// Qualifies hits, forms bin addresses and keeps the scalar event counters.
// ----------------------------------------------------------------------------
`default_nettype none

module tdch_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [31:0] hit_time_i,
  input  wire logic signed [7:0]  hit_row_i,
  input  wire logic signed [7:0]  hit_col_i,
  input  wire logic [5:0]         bin_index_i,
  input  wire logic signed [31:0] threshold_i,
  output tdch_pkg::s1_t           item_o
);
  import tdch_pkg::*;

  op_e    op;
  logic   in_grid;
  logic   hit_ok;
  evcnt_t ev_hits_q, ev_hits_d;
  cnt_t   total_q, total_d;
  cnt_t   hev_q, hev_d;
  cnt_t   ev_q, ev_d;
  logic [CH_W-1:0]  hit_ch;
  logic [BIN_W-1:0] end_bin;

  assign op      = op_e'(op_i);
  assign in_grid = (hit_row_i >= 0) && (hit_row_i < ROWS) &&
                   (hit_col_i >= 0) && (hit_col_i < COLS);
  assign hit_ok  = (hit_time_i >= threshold_i) && in_grid;
  assign hit_ch  = CH_W'(int'(hit_row_i) * COLS + int'(hit_col_i));
  // Events with MULT_BINS-1 or more hits all land in the last bin.
  assign end_bin = (int'(ev_hits_q) >= MULT_BINS - 1) ? BIN_W'(MULT_BINS - 1)
                                                      : BIN_W'(ev_hits_q);

  always_comb begin
    ev_hits_d = ev_hits_q;
    total_d   = total_q;
    hev_d     = hev_q;
    ev_d      = ev_q;
    if (accept_i) begin
      case (op)
        OP_HIT: begin
          if (hit_ok) begin
            total_d = sat_inc(total_q);
            if (ev_hits_q != EV_MAX) begin
              ev_hits_d = ev_hits_q + evcnt_t'(1);
            end
          end
        end
        OP_END: begin
          ev_d      = sat_inc(ev_q);
          if (ev_hits_q != '0) begin
            hev_d = sat_inc(hev_q);
          end
          ev_hits_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_hits_q <= '0;
      total_q   <= '0;
      hev_q     <= '0;
      ev_q      <= '0;
    end else begin
      ev_hits_q <= ev_hits_d;
      total_q   <= total_d;
      hev_q     <= hev_d;
      ev_q      <= ev_d;
    end
  end

  always_comb begin
    item_o            = '0;
    item_o.op         = op;
    item_o.hit_ok     = hit_ok;
    item_o.evt_value  = OUT_W'(ev_hits_q);
    item_o.total      = to_out(total_d);
    item_o.hit_events = to_out(hev_d);
    item_o.events     = to_out(ev_d);
    case (op)
      OP_HIT: begin
        item_o.ch_addr = hit_ch;
        item_o.rd_ok   = hit_ok;
      end
      OP_END: begin
        item_o.bin_addr = end_bin;
        item_o.rd_ok    = 1'b1;
      end
      OP_RDCH: begin
        item_o.ch_addr = CH_W'(bin_index_i);
        item_o.rd_ok   = (int'(bin_index_i) < NCHAN);
      end
      OP_RDMB: begin
        item_o.bin_addr = BIN_W'(bin_index_i);
        item_o.rd_ok    = (int'(bin_index_i) < MULT_BINS);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/tdc_hit_histogrammer.sv
// ----------------------------------------------------------------------------
// TDC hit histogrammer
// Per-channel hit histogram and per-event hit multiplicity histogram.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled
// and returns one result for each, held first in the second-stage register
// and then in the output register. The front stage qualifies the item and
// updates the scalar counters; the channel and multiplicity bins live in two
// RAMs with a registered read, and the second stage increments the bin read
// and writes it back. A write and a read of the same bin in one cycle are
// resolved write-first inside the RAM, so back-to-back hits on one channel
// need no stall. Per-entry valid bits clear both histograms at reset, so no
// clearing pass is needed. A stalled output holds both stages; ready then
// drops until the result is taken.
`default_nettype none

module tdc_hit_histogrammer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tdch_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic signed [31:0]          hit_time_i,
  input  wire logic signed [7:0]           hit_row_i,
  input  wire logic signed [7:0]           hit_col_i,
  input  wire logic [5:0]                  bin_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [31:0]                 value_o,
  output logic      [31:0]                 total_hits_o,
  output logic      [31:0]                 events_with_hits_o,
  output logic      [31:0]                 events_seen_o
);
  import tdch_pkg::*;

  logic signed [31:0] threshold;
  logic               advance;
  logic               accept;
  s1_t                s0_item;
  s1_t                s1_q;
  logic               s1_valid_q;
  cnt_t               ch_rdata, mb_rdata;
  logic               ch_we, mb_we;
  logic [OUT_W-1:0]   value_d;
  logic               out_valid_q;
  logic [OUT_W-1:0]   value_q, total_q, hev_q, ev_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  tdch_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold)
  );

  tdch_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .hit_time_i  (hit_time_i),
    .hit_row_i   (hit_row_i),
    .hit_col_i   (hit_col_i),
    .bin_index_i (bin_index_i),
    .threshold_i (threshold),
    .item_o      (s0_item)
  );

  // Writes happen only when the pipeline moves, so a stalled item keeps
  // its read data and nothing in the RAMs changes beneath it.
  assign ch_we = advance && s1_valid_q && (s1_q.op == OP_HIT) && s1_q.hit_ok;
  assign mb_we = advance && s1_valid_q && (s1_q.op == OP_END);

  tdch_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NCHAN)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (s0_item.ch_addr),
    .rdata_o (ch_rdata),
    .we_i    (ch_we),
    .waddr_i (s1_q.ch_addr),
    .wdata_i (sat_inc(ch_rdata))
  );

  tdch_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MULT_BINS)
  ) u_mult_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (s0_item.bin_addr),
    .rdata_o (mb_rdata),
    .we_i    (mb_we),
    .waddr_i (s1_q.bin_addr),
    .wdata_i (sat_inc(mb_rdata))
  );

  always_comb begin
    case (s1_q.op)
      OP_HIT:  value_d = OUT_W'(s1_q.hit_ok);
      OP_END:  value_d = s1_q.evt_value;
      OP_RDCH: value_d = s1_q.rd_ok ? to_out(ch_rdata) : '0;
      OP_RDMB: value_d = s1_q.rd_ok ? to_out(mb_rdata) : '0;
      default: value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s0_item;
    end
    if (advance && s1_valid_q) begin
      value_q <= value_d;
      total_q <= s1_q.total;
      hev_q   <= s1_q.hit_events;
      ev_q    <= s1_q.events;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign value_o            = value_q;
  assign total_hits_o       = total_q;
  assign events_with_hits_o = hev_q;
  assign events_seen_o      = ev_q;

endmodule

`default_nettype wire

>>> hdl/tdch_sva.sv
// ----------------------------------------------------------------------------
// TDC hit histogrammer port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tdc_hit_histogrammer_defines.svh"

module tdch_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] value_o,
  input wire logic [31:0] total_hits_o,
  input wire logic [31:0] events_with_hits_o,
  input wire logic [31:0] events_seen_o
);

  // A result that is not taken stays offered with the same value and total hit count.
  `TDCH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(value_o) && $stable(total_hits_o))

  // The input side only stalls behind a waiting result.
  `TDCH_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o)

  // An event is counted as having hits only when it is also counted as seen.
  `TDCH_ASSERT_NOW(a_event_order, clk_i, rst_ni, out_valid_o, events_with_hits_o <= events_seen_o)

  // Successive results never report fewer accepted hits.
  `TDCH_ASSERT_NOW(a_total_mono, clk_i, rst_ni, out_valid_o && $past(out_valid_o && out_ready_i), total_hits_o >= $past(total_hits_o))

endmodule

bind tdc_hit_histogrammer tdch_sva u_tdch_sva (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .value_o            (value_o),
  .total_hits_o       (total_hits_o),
  .events_with_hits_o (events_with_hits_o),
  .events_seen_o      (events_seen_o)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC hit histogrammer testbench
// Sends directed and random hit, end-of-event and read transfers with random
// gaps and back pressure, across several time thresholds set over the APB
// port. A running copy of the histograms predicts every result, and each
// result is compared field by field, in order, as it is taken.
// ----------------------------------------------------------------------------
module testbench;
  import tdch_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int LONG_EVENT_HITS = 70;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] total_hits;
    logic [31:0] events_with_hits;
    logic [31:0] events_seen;
  } report_t;

  // Running copy of the histograms, counters and threshold, plus the results
  // that are owed by the block in transfer order.
  class hit_tally;
    logic signed [31:0]     threshold;
    logic [COUNT_WIDTH-1:0] chan_hits [NCHAN];
    logic [COUNT_WIDTH-1:0] mult_hist [MULT_BINS];
    logic [15:0]            event_hits;
    logic [COUNT_WIDTH-1:0] hits_total;
    logic [COUNT_WIDTH-1:0] hit_events;
    logic [COUNT_WIDTH-1:0] events_total;
    report_t                owed_reports[$];
    int                     failures;

    function new();
      threshold    = '0;
      event_hits   = '0;
      hits_total   = '0;
      hit_events   = '0;
      events_total = '0;
      failures     = 0;
      foreach (chan_hits[i]) chan_hits[i] = '0;
      foreach (mult_hist[i]) mult_hist[i] = '0;
    endfunction

    function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function void take_item(op_e op, logic signed [31:0] t, logic signed [7:0] row,
                            logic signed [7:0] col, logic [5:0] idx);
      report_t r;
      int      ch;
      int      b;
      r.value = '0;
      case (op)
        OP_HIT: begin
          if (t >= threshold && row >= 0 && row < ROWS && col >= 0 && col < COLS) begin
            ch = int'(row) * COLS + int'(col);
            chan_hits[ch] = bump(chan_hits[ch]);
            hits_total = bump(hits_total);
            if (event_hits != 16'hFFFF) event_hits = event_hits + 1'b1;
            r.value = 32'd1;
          end
        end
        OP_END: begin
          // Events at or above the last bin all land in the last bin.
          b = (int'(event_hits) > MULT_BINS - 1) ? MULT_BINS - 1 : int'(event_hits);
          mult_hist[b] = bump(mult_hist[b]);
          events_total = bump(events_total);
          if (event_hits != 0) hit_events = bump(hit_events);
          r.value = 32'(event_hits);
          event_hits = '0;
        end
        OP_RDCH: begin
          if (int'(idx) < NCHAN) r.value = 32'(chan_hits[idx[CH_W-1:0]]);
        end
        default: begin
          if (int'(idx) < MULT_BINS) r.value = 32'(mult_hist[idx]);
        end
      endcase
      r.total_hits       = 32'(hits_total);
      r.events_with_hits = 32'(hit_events);
      r.events_seen      = 32'(events_total);
      owed_reports.push_back(r);
    endfunction

    function void match_report(report_t got);
      report_t want;
      if (owed_reports.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result with nothing owed: value %0d", got.value);
        return;
      end
      want = owed_reports.pop_front();
      if (got.value !== want.value || got.total_hits !== want.total_hits ||
          got.events_with_hits !== want.events_with_hits ||
          got.events_seen !== want.events_seen) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: value exp %0d got %0d, total_hits exp %0d got %0d",
                   want.value, got.value, want.total_hits, got.total_hits);
          $display("  events_with_hits exp %0d got %0d, events_seen exp %0d got %0d",
                   want.events_with_hits, got.events_with_hits,
                   want.events_seen, got.events_seen);
        end
      end
    endfunction

    function int owed();
      return owed_reports.size();
    endfunction
  endclass

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_AW-1:0]      paddr   = '0;
  logic [31:0]            pwdata  = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_ready_o;
  op_e                    item_op  = OP_HIT;
  logic signed [31:0]     item_time = '0;
  logic signed [7:0]      item_row  = '0;
  logic signed [7:0]      item_col  = '0;
  logic [5:0]             item_bin  = '0;
  logic                   out_valid_o;
  logic                   out_ready = 1'b0;
  logic [31:0]            value_o;
  logic [31:0]            total_hits_o;
  logic [31:0]            events_with_hits_o;
  logic [31:0]            events_seen_o;

  hit_tally tally;
  bit       src_idle = 1'b1;
  bit       snk_idle = 1'b1;
  bit       hold_req = 1'b0;
  int       sent     = 0;
  int       idle_run = 0;

  tdc_hit_histogrammer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .op_i               (item_op),
    .hit_time_i         (item_time),
    .hit_row_i          (item_row),
    .hit_col_i          (item_col),
    .bin_index_i        (item_bin),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .value_o            (value_o),
    .total_hits_o       (total_hits_o),
    .events_with_hits_o (events_with_hits_o),
    .events_seen_o      (events_seen_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic send(op_e op, logic signed [31:0] t, logic signed [7:0] row,
                      logic signed [7:0] col, logic [5:0] idx);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    item_op   <= op;
    item_time <= t;
    item_row  <= row;
    item_col  <= col;
    item_bin  <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    tally.take_item(op, t, row, col, idx);
    sent++;
  endtask

  task automatic send_hit();
    logic signed [31:0] t;
    logic signed [7:0]  row;
    logic signed [7:0]  col;
    case ($urandom_range(0, 4))
      0:       t = tally.threshold;
      1:       t = tally.threshold - 1;
      2:       t = tally.threshold + 1;
      3:       t = $urandom;
      default: t = tally.threshold + $urandom_range(0, 4096);
    endcase
    row = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, ROWS - 1));
    col = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, COLS - 1));
    send(OP_HIT, t, row, col, 6'($urandom));
  endtask

  task automatic send_read();
    send($urandom_range(0, 1) ? OP_RDCH : OP_RDMB, $urandom, 8'($urandom), 8'($urandom),
         6'($urandom));
  endtask

  task automatic random_event();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 80) : $urandom_range(0, 8);
    repeat (n) begin
      send_hit();
      if ($urandom_range(0, 7) == 0) send_read();
    end
    send(OP_END, $urandom, 8'($urandom), 8'($urandom), 6'($urandom));
  endtask

  // Waits until every owed result has been taken; all ops produce a result.
  task automatic drain();
    in_valid <= 1'b0;
    while (tally.owed() != 0) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic signed [31:0] thr);
    drain();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * REG_TIME_THRESHOLD);
    pwdata  <= thr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tally.threshold = thr;
  endtask

  task automatic random_phase(logic signed [31:0] thr, bit src_on, bit snk_on, bit hold);
    int first;
    set_threshold(thr);
    src_idle = src_on;
    snk_idle = snk_on;
    if (hold) hold_req = 1'b1;
    first = sent;
    while (sent - first < ITEMS_PER_PHASE) begin
      if ($urandom_range(0, 4) == 0) begin
        // Noise: any op with every field random.
        send(op_e'($urandom_range(0, 3)), $urandom, 8'($urandom), 8'($urandom),
             6'($urandom));
      end else begin
        random_event();
      end
    end
  endtask

  // Result side: random gaps, plus one long hold-off when requested.
  initial begin
    int gap;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = snk_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      tally.match_report('{value_o, total_hits_o, events_with_hits_o, events_seen_o});
    end
  end

  initial begin
    logic signed [31:0] thr;
    tally = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, threshold still at its reset value of zero.
    send(OP_RDCH, 0, 0, 0, 6'd0);
    send(OP_RDMB, 0, 0, 0, 6'd0);
    send(OP_END, 0, 0, 0, 6'd0);
    send(OP_HIT, 32'sd0, 8'sd0, 8'sd0, 6'd0);
    send(OP_HIT, -32'sd1, 8'sd0, 8'sd0, 6'd0);
    send(OP_HIT, 32'sh7FFF_FFFF, 8'sd7, 8'sd3, 6'd63);
    send(OP_HIT, 32'sh8000_0000, 8'sd1, 8'sd1, 6'd0);
    send(OP_HIT, 32'sd16, 8'sd8, 8'sd0, 6'd0);
    send(OP_HIT, 32'sd16, -8'sd1, 8'sd0, 6'd0);
    send(OP_HIT, 32'sd16, 8'sd0, 8'sd4, 6'd0);
    send(OP_HIT, 32'sd16, 8'sd127, -8'sd128, 6'd0);
    send(OP_HIT, 32'sd16, -8'sd128, 8'sd127, 6'd0);
    // Three hits on one channel, with random gaps, then a read of it.
    send(OP_HIT, 32'sd32, 8'sd5, 8'sd1, 6'd0);
    send(OP_HIT, 32'sd32, 8'sd5, 8'sd1, 6'd0);
    send(OP_HIT, 32'sd32, 8'sd5, 8'sd1, 6'd0);
    send(OP_RDCH, 0, 0, 0, 6'd21);
    send(OP_END, 0, 0, 0, 6'd0);
    send(OP_RDCH, 0, 0, 0, 6'd0);
    send(OP_RDCH, 0, 0, 0, 6'd31);
    send(OP_RDCH, 0, 0, 0, 6'd32);
    send(OP_RDCH, 0, 0, 0, 6'd63);
    send(OP_RDMB, 0, 0, 0, 6'd5);
    send(OP_RDMB, 0, 0, 0, 6'd63);
    send(OP_END, 0, 0, 0, 6'd0);

    random_phase(32'sh8000_0000, 1'b1, 1'b1, 1'b0);

    // One event long enough to spill into the last multiplicity bin, with no gaps.
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (LONG_EVENT_HITS) begin
      send(OP_HIT, $urandom, 8'($urandom_range(0, ROWS - 1)),
           8'($urandom_range(0, COLS - 1)), 6'($urandom));
    end
    send(OP_END, 0, 0, 0, 6'd0);
    send(OP_RDMB, 0, 0, 0, 6'd63);
    send(OP_RDCH, 0, 0, 0, 6'd0);

    random_phase(32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0);
    random_phase($urandom, 1'b0, 1'b1, 1'b1);
    thr = $urandom_range(0, 4096);
    random_phase(thr - 2048, 1'b1, 1'b1, 1'b0);
    random_phase(32'sd0, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tally.failures == 0 && tally.owed() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
